@@ hw/rtl/vorf_pkg.sv @@
// vorf_pkg: shared types and constants of the voxel occupancy ray fill unit
// used by the controller, the datapath and the top level; no dependencies

package vorf_pkg;

  localparam int GRID_DIM   = 32;
  localparam int KEY_W      = $clog2(GRID_DIM);
  localparam int ADDR_W     = 3 * KEY_W;
  localparam int CELL_COUNT = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int WALK_MAX   = 3 * GRID_DIM + 3;
  localparam int WALK_W     = $clog2(WALK_MAX);

  localparam int CFG_W   = 60;
  localparam int CFG_IDX_W = 3;

  localparam int MAG_W   = 26;
  localparam int NUM_W   = 21;
  localparam int PROD_W  = 54;
  localparam int UOP_W   = 5;

  // micro-op schedule of one point
  localparam logic [UOP_W-1:0] UOP_G0    = 5'd10;
  localparam logic [UOP_W-1:0] UOP_D0    = 5'd13;
  localparam logic [UOP_W-1:0] UOP_CHECK = 5'd17;
  localparam logic [UOP_W-1:0] UOP_X0    = 5'd18;
  localparam logic [UOP_W-1:0] UOP_LAST  = 5'd24;
  localparam logic [UOP_W-1:0] UOP_XFRM  = 5'd9;

  localparam logic [1:0] ROW_OF [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] COL_OF [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

  // cross product k is num[PAIR_A[k]] * mag[PAIR_B[k]]
  localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [6] = '{2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1};

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOX    = 3'd6;

  localparam logic [1:0] VOX_FREE = 2'd0;
  localparam logic [1:0] VOX_HIT  = 2'd1;
  localparam logic [1:0] VOX_OCC  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_WALK,
    S_READ
  } state_t;

  typedef struct packed {
    logic              load;
    logic              uop_en;
    logic [UOP_W-1:0]  uop;
    logic              check;
    logic              hit_we;
    logic              walk;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              rd_en;
    logic              out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic fill;
    logic no_step;
    logic walk_out;
    logic out_busy;
  } dp_status_t;

endpackage

@@ hw/rtl/vorf_ram.sv @@
// vorf_ram: generic single write, single read RAM with registered read
// no dependencies

module vorf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/vorf_ctrl.sv @@
// vorf_ctrl: sequencer of the voxel fill unit (clear sweep, transform, ray walk, read)
// depends on vorf_pkg

module vorf_ctrl import vorf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] command,
  input  logic       point_invalid,
  input  dp_status_t sts,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  state_t            state, state_next;
  logic [UOP_W-1:0]  uop, uop_next;
  logic [WALK_W-1:0] walk_cnt, walk_cnt_next;
  logic [ADDR_W-1:0] sweep, sweep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      uop      <= '0;
      walk_cnt <= '0;
      sweep    <= '0;
    end else begin
      state    <= state_next;
      uop      <= uop_next;
      walk_cnt <= walk_cnt_next;
      sweep    <= sweep_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    uop_next      = uop;
    walk_cnt_next = walk_cnt;
    sweep_next    = sweep;
    cmd           = '0;
    cmd.uop       = uop;
    cmd.clr_addr  = sweep;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (command)
            CMD_ADD: begin
              if (!point_invalid) begin
                state_next = S_ADD;
                uop_next   = '0;
              end
            end
            CMD_READ: begin
              cmd.rd_en  = 1'b1;
              state_next = S_READ;
            end
            CMD_CLEAR: begin
              state_next = S_CLEAR;
              sweep_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        cmd.uop_en = 1'b1;
        uop_next   = uop + 1'b1;
        if (uop == UOP_CHECK) begin
          cmd.check = 1'b1;
          if (!sts.in_grid) begin
            state_next = S_IDLE;
          end else begin
            cmd.hit_we = 1'b1;
            if (!sts.fill || sts.no_step) begin
              state_next = S_IDLE;
            end
          end
        end
        if (uop == UOP_LAST) begin
          state_next    = S_WALK;
          walk_cnt_next = '0;
        end
      end
      S_WALK: begin
        cmd.walk      = 1'b1;
        walk_cnt_next = walk_cnt + 1'b1;
        if (sts.walk_out || walk_cnt == WALK_W'(WALK_MAX - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/vorf_dpath.sv @@
// vorf_dpath: configuration registers, shared multiplier, ray walk datapath,
// voxel store and output register; depends on vorf_pkg and vorf_ram

module vorf_dpath import vorf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic signed [19:0]   point_x,
  input  logic signed [19:0]   point_y,
  input  logic signed [19:0]   point_z,
  input  logic [14:0]          voxel_index,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [2:0]    voxel_value
);

  logic [47:0] rot_x, rot_y, rot_z, inv_size;
  logic [59:0] trans, origin;
  logic [36:0] box_fill;

  logic signed [19:0] pt [3];
  logic [14:0]        idx;

  logic signed [37:0] acc [3];
  logic signed [42:0] g [3];
  logic signed [40:0] d [3];

  logic signed [26:0] ma;
  logic signed [21:0] mb;
  logic signed [48:0] prod;
  logic [UOP_W-1:0]   tag;
  logic               tag_vld;

  logic [KEY_W-1:0]  key [3];
  logic [MAG_W-1:0]  mag [3];
  logic [NUM_W-1:0]  num_init [3];
  logic              dneg [3];
  logic [PROD_W-1:0] pr [6];

  logic signed [15:0] rot_e [9];
  logic signed [23:0] s [3];
  logic signed [24:0] obj [3];
  logic signed [25:0] gdiff [3];
  logic [15:0]        inv [3];
  logic [MAG_W-1:0]   mag_new [3];
  logic [KEY_W-1:0]   key_new [3];
  logic [4:0]         uo_g, uo_d, uo_x, tg_g, tg_d, tg_x;

  logic              lt01, lt02, lt12;
  logic [1:0]        dim;
  logic [KEY_W:0]    step_key;
  logic [KEY_W-1:0]  wkey [3];

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [1:0]        ram_wdata, ram_rdata;
  logic              in_box;
  logic [2:0]        v3;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x    <= 48'd16384;
      rot_y    <= 48'd16384 << 16;
      rot_z    <= 48'd16384 << 32;
      trans    <= '0;
      origin   <= '0;
      inv_size <= 48'h1000_1000_1000;
      box_fill <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROT_X:  rot_x    <= cfg_data[47:0];
        REG_ROT_Y:  rot_y    <= cfg_data[47:0];
        REG_ROT_Z:  rot_z    <= cfg_data[47:0];
        REG_TRANS:  trans    <= cfg_data;
        REG_ORIGIN: origin   <= cfg_data;
        REG_INV:    inv_size <= cfg_data[47:0];
        REG_BOX:    box_fill <= cfg_data[36:0];
        default: ;
      endcase
    end
  end

  // combinational views of registers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot_e[i]     = rot_x[16*i +: 16];
      rot_e[i + 3] = rot_y[16*i +: 16];
      rot_e[i + 6] = rot_z[16*i +: 16];
    end
    for (int r = 0; r < 3; r++) begin
      logic signed [37:0] rnd;
      rnd      = acc[r] + 38'sd8192;
      s[r]     = rnd[37:14];
      obj[r]   = {s[r][23], s[r]} + {{5{trans[20*r+19]}}, trans[20*r +: 20]};
      gdiff[r] = {obj[r][24], obj[r]} - {{6{origin[20*r+19]}}, origin[20*r +: 20]};
      inv[r]   = inv_size[16*r +: 16];
      mag_new[r] = MAG_W'(d[r][40] ? 41'(-d[r]) >> 12 : 41'(d[r]) >> 12);
      key_new[r] = g[r][20 +: KEY_W];
    end
  end

  assign uo_g = cmd.uop - UOP_G0;
  assign uo_d = cmd.uop - UOP_D0;
  assign uo_x = cmd.uop - UOP_X0;
  assign tg_g = tag - UOP_G0;
  assign tg_d = tag - UOP_D0;
  assign tg_x = tag - UOP_X0;

  // operand select of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.uop < UOP_XFRM) begin
      ma = {{11{rot_e[cmd.uop[3:0]][15]}}, rot_e[cmd.uop[3:0]]};
      mb = {{2{pt[COL_OF[cmd.uop[3:0]]][19]}}, pt[COL_OF[cmd.uop[3:0]]]};
    end else if (cmd.uop >= UOP_G0 && cmd.uop < UOP_D0) begin
      ma = {gdiff[uo_g[1:0]][25], gdiff[uo_g[1:0]]};
      mb = {6'd0, inv[uo_g[1:0]]};
    end else if (cmd.uop >= UOP_D0 && cmd.uop < UOP_CHECK) begin
      ma = {{3{s[uo_d[1:0]][23]}}, s[uo_d[1:0]]};
      mb = {6'd0, inv[uo_d[1:0]]};
    end else if (cmd.uop >= UOP_X0 && cmd.uop < UOP_LAST) begin
      ma = {1'b0, mag[PAIR_B[uo_x[2:0]]]};
      mb = {1'b0, num_init[PAIR_A[uo_x[2:0]]]};
    end
  end

  // crossing time compare, a stalled axis never wins
  always_comb begin
    lt01 = (mag[0] != '0) && ((mag[1] == '0) || (pr[0] < pr[1]));
    lt02 = (mag[0] != '0) && ((mag[2] == '0) || (pr[2] < pr[3]));
    lt12 = (mag[1] != '0) && ((mag[2] == '0) || (pr[4] < pr[5]));
    if (lt01) begin
      dim = lt02 ? 2'd0 : 2'd2;
    end else begin
      dim = lt12 ? 2'd1 : 2'd2;
    end
    step_key = dneg[dim] ? {1'b0, key[dim]} - 1'b1 : {1'b0, key[dim]} + 1'b1;
    for (int r = 0; r < 3; r++) begin
      wkey[r] = (2'(r) == dim) ? step_key[KEY_W-1:0] : key[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_vld <= 1'b0;
    end else begin
      tag_vld <= cmd.uop_en;
    end
    prod <= ma * mb;
    tag  <= cmd.uop;
    if (cmd.load) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
      idx   <= voxel_index;
      for (int r = 0; r < 3; r++) begin
        acc[r] <= '0;
      end
    end
    if (tag_vld) begin
      if (tag < UOP_XFRM) begin
        acc[ROW_OF[tag[3:0]]] <= acc[ROW_OF[tag[3:0]]] + prod[37:0];
      end else if (tag >= UOP_G0 && tag < UOP_D0) begin
        g[tg_g[1:0]] <= prod[42:0];
      end else if (tag >= UOP_D0 && tag < UOP_CHECK) begin
        d[tg_d[1:0]] <= prod[40:0];
      end else if (tag >= UOP_X0 && tag < UOP_LAST) begin
        pr[tg_x[2:0]] <= {{(PROD_W-49){1'b0}}, prod};
      end
    end
    if (cmd.check) begin
      for (int r = 0; r < 3; r++) begin
        key[r]  <= key_new[r];
        mag[r]  <= mag_new[r];
        dneg[r] <= d[r][40];
        num_init[r] <= d[r][40] ? {1'b0, g[r][19:0]} : (NUM_W'(1) << 20) - {1'b0, g[r][19:0]};
      end
    end
    if (cmd.walk) begin
      key[dim] <= step_key[KEY_W-1:0];
      for (int k = 0; k < 6; k++) begin
        if (PAIR_A[k] == dim) begin
          pr[k] <= pr[k] + ({{(PROD_W-MAG_W){1'b0}}, mag[PAIR_B[k]]} << 20);
        end
      end
    end
  end

  // voxel store
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd.clr_addr;
    ram_wdata = VOX_FREE;
    if (cmd.clr_we) begin
      ram_we = 1'b1;
    end else if (cmd.hit_we) begin
      ram_we    = 1'b1;
      ram_waddr = {key_new[0], key_new[1], key_new[2]};
      ram_wdata = VOX_HIT;
    end else if (cmd.walk && !step_key[KEY_W]) begin
      ram_we    = 1'b1;
      ram_waddr = {wkey[0], wkey[1], wkey[2]};
      ram_wdata = VOX_OCC;
    end
  end

  vorf_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (voxel_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // read answer, negated inside the object box
  always_comb begin
    in_box = ({1'b0, idx[14:10]} >= box_fill[5:0])   && ({1'b0, idx[14:10]} <= box_fill[23:18]) &&
             ({1'b0, idx[9:5]}   >= box_fill[11:6])  && ({1'b0, idx[9:5]}   <= box_fill[29:24]) &&
             ({1'b0, idx[4:0]}   >= box_fill[17:12]) && ({1'b0, idx[4:0]}   <= box_fill[35:30]);
    v3 = {1'b0, ram_rdata};
    if (in_box) begin
      v3 = 3'(-v3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      voxel_value <= v3;
    end
  end

  always_comb begin
    sts.in_grid  = 1'b1;
    sts.no_step  = 1'b1;
    for (int r = 0; r < 3; r++) begin
      if (g[r][42] || g[r] == '0 || g[r][41:KEY_W+20] != '0) begin
        sts.in_grid = 1'b0;
      end
      if (mag_new[r] != '0) begin
        sts.no_step = 1'b0;
      end
    end
    sts.fill     = box_fill[36];
    sts.walk_out = step_key[KEY_W];
    sts.out_busy = out_valid && out_stall;
  end

endmodule

@@ hw/rtl/voxel_occupancy_ray_fill_unit.sv @@
// add point: transform and grid test, then crossing setup on one shared multiplier,
// then the ray walk at one voxel per cycle, up to 3*GRID_DIM+3 steps
// read: registered store read, then the output register, which waits while a word is held
// clear: one voxel a cycle through the store write port, input stalled
// reset: configuration to defaults, then the same clearing pass
// one item at a time; throughput follows the walk length of each point

module voxel_occupancy_ray_fill_unit import vorf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic signed [19:0]   point_x,
  input  logic signed [19:0]   point_y,
  input  logic signed [19:0]   point_z,
  input  logic                 point_invalid,
  input  logic [14:0]          voxel_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [2:0]    voxel_value
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  vorf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .command       (command),
    .point_invalid (point_invalid),
    .sts           (sts),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  vorf_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .voxel_index (voxel_index),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .voxel_value (voxel_value)
  );

  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("input taken before clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("waiting word overwritten");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.walk && sts.walk_out |=> !cmd.walk)
    else $error("walk continued past grid");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit_we && (cmd.walk || cmd.clr_we)))
    else $error("store write conflict");

endmodule

@@ tb/voxel_grid_checker.sv @@
// voxel_grid_checker: watches the config port and both word channels of the voxel
// occupancy ray fill unit, keeps its own occupancy grid and compares every read word
// depends on vorf_pkg for the grid size, register indexes, commands and voxel codes

module voxel_grid_checker import vorf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           command,
  input  logic signed [19:0]   point_x,
  input  logic signed [19:0]   point_y,
  input  logic signed [19:0]   point_z,
  input  logic                 point_invalid,
  input  logic [14:0]          voxel_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [2:0]    voxel_value,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] rot [3];
  logic [59:0] trans, origin;
  logic [47:0] inv_size;
  logic [36:0] box_fill;
  logic [1:0]  grid [CELL_COUNT];
  logic signed [2:0] expected_voxels [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // crossing time a/da earlier than b/db; an axis that never steps is never earlier
  function automatic logic earlier(longint unsigned a, longint unsigned da, logic ia,
                                   longint unsigned b, longint unsigned db, logic ib);
    if (ia) return 1'b0;
    if (ib) return 1'b1;
    return (a * db) < (b * da);
  endfunction

  function automatic void trace_point(logic signed [19:0] px, logic signed [19:0] py,
                                      logic signed [19:0] pz);
    longint p [3];
    longint obj [3];
    longint g [3];
    longint tr [3];
    longint iv [3];
    longint acc, d;
    longint unsigned num [3];
    longint unsigned mag [3];
    longint unsigned ad;
    int key [3];
    int stp [3];
    int dim;
    logic [47:0] rowv;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      rowv = rot[r];
      for (int c = 0; c < 3; c++)
        acc += longint'($signed(rowv[16*c +: 16])) * p[c];
      tr[r] = longint'($signed(trans[20*r +: 20]));
      iv[r] = longint'(inv_size[16*r +: 16]);
      obj[r] = ((acc + 64'sd8192) >>> 14) + tr[r];
      g[r] = (obj[r] - longint'($signed(origin[20*r +: 20]))) * iv[r];
      if (g[r] <= 0 || g[r] >= (longint'(GRID_DIM) <<< 20)) return;
      key[r] = int'(g[r] >>> 20);
    end
    grid[(key[0] * GRID_DIM + key[1]) * GRID_DIM + key[2]] = VOX_HIT;
    if (!box_fill[36]) return;

    for (int r = 0; r < 3; r++) begin
      d = (obj[r] - tr[r]) * iv[r];
      ad = (d < 0) ? -d : d;
      mag[r] = ad >> 12;
      if (mag[r] == 0) begin
        stp[r] = 0;
        num[r] = 0;
      end else if (d < 0) begin
        stp[r] = -1;
        num[r] = g[r] - (longint'(key[r]) <<< 20);
      end else begin
        stp[r] = 1;
        num[r] = ((longint'(key[r]) + 1) <<< 20) - g[r];
      end
    end
    if (stp[0] == 0 && stp[1] == 0 && stp[2] == 0) return;

    // walk from the far face of the start voxel away from the camera
    for (int n = 0; n < WALK_MAX; n++) begin
      if (earlier(num[0], mag[0], stp[0] == 0, num[1], mag[1], stp[1] == 0))
        dim = earlier(num[0], mag[0], stp[0] == 0, num[2], mag[2], stp[2] == 0) ? 0 : 2;
      else
        dim = earlier(num[1], mag[1], stp[1] == 0, num[2], mag[2], stp[2] == 0) ? 1 : 2;
      key[dim] += stp[dim];
      num[dim] += 64'd1 << 20;
      if (key[dim] < 0 || key[dim] >= GRID_DIM) break;
      grid[(key[0] * GRID_DIM + key[1]) * GRID_DIM + key[2]] = VOX_OCC;
    end
  endfunction

  function automatic logic signed [2:0] voxel_lookup(logic [14:0] idx);
    logic signed [2:0] v;
    logic [5:0] x, y, z;
    v = {1'b0, grid[idx]};
    x = {1'b0, idx[14:10]};
    y = {1'b0, idx[9:5]};
    z = {1'b0, idx[4:0]};
    if (v != 0 && x >= box_fill[5:0] && x <= box_fill[23:18] &&
        y >= box_fill[11:6] && y <= box_fill[29:24] &&
        z >= box_fill[17:12] && z <= box_fill[35:30])
      v = -v;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rot[0]   = 48'd16384;
      rot[1]   = 48'd16384 << 16;
      rot[2]   = 48'd16384 << 32;
      trans    = '0;
      origin   = '0;
      inv_size = 48'h1000_1000_1000;
      box_fill = '0;
      foreach (grid[i]) grid[i] = VOX_FREE;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROT_X:  rot[0]   = cfg_data[47:0];
          REG_ROT_Y:  rot[1]   = cfg_data[47:0];
          REG_ROT_Z:  rot[2]   = cfg_data[47:0];
          REG_TRANS:  trans    = cfg_data[59:0];
          REG_ORIGIN: origin   = cfg_data[59:0];
          REG_INV:    inv_size = cfg_data[47:0];
          REG_BOX:    box_fill = cfg_data[36:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (cmd_code_t'(command))
          CMD_ADD:   if (!point_invalid) trace_point(point_x, point_y, point_z);
          CMD_READ:  expected_voxels = {expected_voxels, voxel_lookup(voxel_index)};
          CMD_CLEAR: foreach (grid[i]) grid[i] = VOX_FREE;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_voxels.size() == 0) begin
          $display("%0t unexpected word: expected none, actual voxel_value %0d",
                   $time, voxel_value);
          errors++;
        end else begin
          if (voxel_value !== expected_voxels[0]) begin
            $display("%0t voxel_value mismatch: expected %0d, actual %0d",
                     $time, expected_voxels[0], voxel_value);
            errors++;
          end
          void'(expected_voxels.pop_front());
        end
      end
      pending = expected_voxels.size();
    end
  end
endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for voxel_occupancy_ray_fill_unit
// drives config, points, reads and clears with random idling; voxel_grid_checker
// does the prediction; depends on vorf_pkg

module tb;
  import vorf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 120000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           command;
  logic signed [19:0]   point_x, point_y, point_z;
  logic                 point_invalid;
  logic [14:0]          voxel_index;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [2:0]    voxel_value;
  int                   errors, pending;

  int snd_idle = 20;
  int rcv_idle = 73;
  int hold_left = 0;
  int quiet_cycles = 0;
  int rnd_count = 0;

  // sender-side copy of the setting, used to aim points into the grid
  int          rsg [3][3];
  longint      tr [3];
  longint      org [3];
  longint      ivs [3];
  logic [36:0] box_fill;
  bit          aim;
  logic [59:0] regs [7];
  int          recent [$];

  voxel_occupancy_ray_fill_unit uut (.*);

  voxel_grid_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic put_word(logic [1:0] cmd, logic signed [19:0] x, logic signed [19:0] y,
                          logic signed [19:0] z, logic inv, logic [14:0] idx);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    point_x       <= x;
    point_y       <= y;
    point_z       <= z;
    point_invalid <= inv;
    voxel_index   <= idx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic read_voxel(logic [14:0] idx);
    put_word(CMD_READ, 20'($urandom), 20'($urandom), 20'($urandom), 1'($urandom), idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || in_stall) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic pack_regs();
    foreach (regs[i]) regs[i] = '0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        regs[r][16*c +: 16] = 16'(rsg[r][c] * 16384);
    for (int a = 0; a < 3; a++) begin
      regs[3][20*a +: 20] = 20'(tr[a]);
      regs[4][20*a +: 20] = 20'(org[a]);
      regs[5][16*a +: 16] = 16'(ivs[a]);
    end
    regs[6] = {23'd0, box_fill};
  endtask

  task automatic write_regs();
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= regs[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [36:0] rand_box(bit fill);
    logic [5:0] lo [3];
    logic [5:0] hi [3];
    for (int a = 0; a < 3; a++) begin
      lo[a] = 6'($urandom_range(31));
      hi[a] = 6'($urandom_range(63, lo[a]));
    end
    return {fill, hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
  endfunction

  // pick an object-frame target inside the grid and map it back to the camera frame
  task automatic aimed_point();
    longint tgt [3];
    longint p [3];
    longint ext;
    int k [3];
    for (int r = 0; r < 3; r++) begin
      ext = (longint'(GRID_DIM) <<< 20) / ivs[r];
      tgt[r] = org[r] + 1 + $urandom_range(int'(ext - 2));
      k[r] = int'(((tgt[r] - org[r]) * ivs[r]) >>> 20);
    end
    for (int c = 0; c < 3; c++) begin
      p[c] = 0;
      for (int r = 0; r < 3; r++) p[c] += rsg[r][c] * (tgt[r] - tr[r]);
    end
    recent = {recent, (k[0] * GRID_DIM + k[1]) * GRID_DIM + k[2]};
    if (recent.size() > 16) void'(recent.pop_front());
    put_word(CMD_ADD, 20'(p[0]), 20'(p[1]), 20'(p[2]), ($urandom_range(19) == 0),
             15'($urandom));
  endtask

  task automatic random_word(bit last);
    int pick;
    logic [14:0] idx;
    if (rnd_count < 210) begin
      snd_idle = 20;
      rcv_idle = 73;
    end else if (rnd_count < 420) begin
      snd_idle = 73;
      rcv_idle = 20;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    rnd_count++;
    pick = last ? 60 : $urandom_range(99);
    if (pick < 45 && aim) begin
      aimed_point();
    end else if (pick < 55) begin
      put_word(CMD_ADD, 20'($urandom), 20'($urandom), 20'($urandom),
               ($urandom_range(3) == 0), 15'($urandom));
    end else if (pick < 97) begin
      if (recent.size() > 0 && $urandom_range(2) != 0)
        idx = 15'(recent[$urandom_range(recent.size() - 1)] ^ $urandom_range(3));
      else
        idx = 15'($urandom);
      read_voxel(idx);
    end else begin
      put_word(CMD_NOP, 20'($urandom), 20'($urandom), 20'($urandom), 1'($urandom),
               15'($urandom));
    end
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) random_word(i == count - 1);
    drain();
  endtask

  task automatic set_perm(int r0c, int r0s, int r1c, int r1s, int r2c, int r2s);
    foreach (rsg[r, c]) rsg[r][c] = 0;
    rsg[0][r0c] = r0s;
    rsg[1][r1c] = r1s;
    rsg[2][r2c] = r2s;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    command       = CMD_NOP;
    point_x       = '0;
    point_y       = '0;
    point_z       = '0;
    point_invalid = 1'b0;
    voxel_index   = '0;
    out_stall     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // wait out the clearing pass behind one read at reset defaults
    read_voxel(15'd0);
    drain();

    // identity rotation, camera one metre in on every axis, fill on
    set_perm(0, 1, 1, 1, 2, 1);
    for (int a = 0; a < 3; a++) begin
      tr[a]  = 4096;
      org[a] = 0;
      ivs[a] = 16'h1000;
    end
    box_fill = {1'b1, 6'd20, 6'd20, 6'd20, 6'd8, 6'd8, 6'd8};
    aim = 1;
    pack_regs();
    write_regs();

    put_word(CMD_ADD, 0, 0, 0, 1'b0, 0);                   // no direction, no walk
    read_voxel(15'd16912);
    read_voxel(15'd16913);
    put_word(CMD_ADD, 2048, 0, 0, 1'b0, 0);                // walk along x only
    read_voxel(15'd25104);
    put_word(CMD_ADD, 1000, 1000, 1000, 1'b0, 0);          // equal crossing times
    put_word(CMD_ADD, -1000, -1000, 1000, 1'b0, 0);
    put_word(CMD_ADD, -4096, 0, 0, 1'b0, 0);               // on the low face
    put_word(CMD_ADD, 4096, 0, 0, 1'b0, 0);                // on the high face
    put_word(CMD_ADD, 4095, -4095, 100, 1'b0, 0);
    put_word(CMD_ADD, 20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 1'b0, 0);
    put_word(CMD_ADD, 0, 100, 0, 1'b1, 15'h7FFF);          // skipped point
    read_voxel(15'd16944);
    read_voxel(15'd32767);
    read_voxel(15'd0);
    put_word(CMD_NOP, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1, 15'h7FFF);
    read_voxel(15'd16912);
    put_word(CMD_CLEAR, 0, 0, 0, 1'b0, 0);
    read_voxel(15'd16912);
    read_voxel(15'd25104);
    drain();

    // signed permutation rotation, mixed scale, long output hold-off at the start
    set_perm(1, 1, 2, -1, 0, 1);
    tr  = '{-2000, 3000, 500};
    org = '{-8000, -4000, 1000};
    ivs = '{16'h0800, 16'h1800, 16'h2000};
    box_fill = rand_box(1'b1);
    pack_regs();
    write_regs();
    for (int i = 0; i < 20; i++) aimed_point();
    hold_left = 400;
    for (int i = 0; i < 8; i++) read_voxel(15'(recent[i]));
    random_run(180);
    put_word(CMD_CLEAR, 0, 0, 0, 1'b0, 0);
    random_run(30);

    // extremes: all-ones, most-positive and most-negative fields
    regs[0] = {12'd0, 48'hFFFF_FFFF_FFFF};
    regs[1] = {12'd0, 48'h7FFF_8000_7FFF};
    regs[2] = {12'd0, 48'h8000_7FFF_FFFF};
    regs[3] = '1;
    regs[4] = {20'h80000, 20'h80000, 20'h80000};
    regs[5] = {12'd0, 48'hFFFF_FFFF_FFFF};
    regs[6] = {23'd0, 37'h1F_FFFF_FFFF};
    aim = 0;
    write_regs();
    random_run(50);

    // zero scale: nothing can land in the grid
    regs[5] = '0;
    regs[6] = '0;
    write_regs();
    random_run(20);

    // identity again with fill off and the whole grid inside the box
    set_perm(0, 1, 1, 1, 2, 1);
    tr  = '{0, 0, 0};
    org = '{0, 0, 0};
    ivs = '{16'h1000, 16'h1000, 16'h1000};
    box_fill = {1'b0, 6'd63, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0};
    aim = 1;
    pack_regs();
    write_regs();
    random_run(150);

    // mirrored axes, coarse voxels, large offsets, fill on
    set_perm(0, -1, 1, 1, 2, -1);
    tr  = '{100000, -200000, 5000};
    org = '{90000, -210000, -30000};
    ivs = '{16'h0400, 16'h0400, 16'h0400};
    box_fill = rand_box(1'b1);
    pack_regs();
    write_regs();
    put_word(CMD_CLEAR, 0, 0, 0, 1'b0, 0);
    random_run(190);

    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
